/* sv/ncl_pkg.sv */
// Shared types, constants and helpers for the near-plane triangle clipper.
package ncl_pkg;

    localparam int COORD_W    = 32;
    localparam int NEAR_W     = 31;
    localparam int T_BITS     = 31;
    localparam int T_FRAC     = 30;
    localparam int DIV_STAGES = (T_BITS + 1) / 2;
    localparam logic [NEAR_W-1:0] NEAR_RESET = 31'd655360;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_ONE_IN,
        MODE_TWO_IN,
        MODE_ALL_IN
    } t_mode;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vtx;

    typedef struct packed {
        logic signed [COORD_W:0] x;
        logic signed [COORD_W:0] y;
        logic signed [COORD_W:0] z;
    } t_dvec;

    // q0..q2: pass-through vertices; o1/o2 and d1/d2: crossing origins and deltas
    typedef struct packed {
        t_mode mode;
        t_vtx  q0;
        t_vtx  q1;
        t_vtx  q2;
        t_vtx  o1;
        t_vtx  o2;
        t_dvec d1;
        t_dvec d2;
    } t_side;

    typedef struct packed {
        logic [COORD_W:0]   rem;
        logic [COORD_W-1:0] den;
        logic [T_BITS-1:0]  quo;
    } t_dcr;

    typedef struct packed {
        t_vtx a;
        t_vtx b;
        t_vtx c;
    } t_tri;

    // one restoring division step
    function automatic t_dcr div_step(t_dcr s, logic shift);
        logic [COORD_W+1:0] rr;
        logic [COORD_W+1:0] dd;
        t_dcr n;
        rr = shift ? {s.rem, 1'b0} : {1'b0, s.rem};
        dd = {2'b00, s.den};
        n  = s;
        if (rr >= dd) begin
            n.rem = (COORD_W+1)'(rr - dd);
            n.quo = {s.quo[T_BITS-2:0], 1'b1};
        end else begin
            n.rem = rr[COORD_W:0];
            n.quo = {s.quo[T_BITS-2:0], 1'b0};
        end
        return n;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(logic signed [COORD_W+1:0] v);
        logic signed [COORD_W+1:0] hi;
        logic signed [COORD_W+1:0] lo;
        hi = {3'b000, {(COORD_W-1){1'b1}}};
        lo = {3'b111, {(COORD_W-1){1'b0}}};
        if (v > hi) begin
            return hi[COORD_W-1:0];
        end else if (v < lo) begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

/* sv/ncl_front.sv */
// Input register, inside/outside classification and divider operand setup.
module ncl_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  ncl_pkg::t_vtx                 i_v0,
    input  ncl_pkg::t_vtx                 i_v1,
    input  ncl_pkg::t_vtx                 i_v2,
    input  logic [ncl_pkg::NEAR_W-1:0]    i_near,
    output logic                          o_valid,
    output ncl_pkg::t_side                o_side,
    output ncl_pkg::t_dcr                 o_c1,
    output ncl_pkg::t_dcr                 o_c2
);
    import ncl_pkg::*;

    logic              r_vld1;
    t_vtx              r_v0, r_v1, r_v2;
    logic [NEAR_W-1:0] r_near;

    logic  r_vld2;
    t_side r_side;
    t_dcr  r_c1, r_c2;

    logic [2:0] w_in;
    t_mode      w_mode;
    t_vtx       w_q0, w_q1, w_q2;
    t_vtx       w_o1, w_p1, w_o2, w_p2;
    t_side      n_side;
    t_dcr       n_c1, n_c2;
    logic signed [COORD_W-1:0] w_near;

    function automatic t_dvec delta(t_vtx p, t_vtx o);
        t_dvec d;
        d.x = {p.x[COORD_W-1], p.x} - {o.x[COORD_W-1], o.x};
        d.y = {p.y[COORD_W-1], p.y} - {o.y[COORD_W-1], o.y};
        d.z = {p.z[COORD_W-1], p.z} - {o.z[COORD_W-1], o.z};
        return d;
    endfunction

    function automatic t_dcr div_init(t_vtx o, t_vtx p, logic signed [COORD_W-1:0] nr);
        t_dcr c;
        logic [COORD_W:0] num;
        logic [COORD_W:0] den;
        num   = {nr[COORD_W-1], nr} - {o.z[COORD_W-1], o.z};
        den   = {p.z[COORD_W-1], p.z} - {o.z[COORD_W-1], o.z};
        c.rem = {1'b0, num[COORD_W-1:0]};
        c.den = den[COORD_W-1:0];
        c.quo = '0;
        return c;
    endfunction

    assign w_near = {1'b0, r_near};
    assign w_in   = {r_v2.z >= w_near, r_v1.z >= w_near, r_v0.z >= w_near};

    always_comb begin
        w_mode = MODE_NONE;
        w_q0 = r_v0; w_q1 = r_v1; w_q2 = r_v2;
        w_o1 = r_v0; w_p1 = r_v1; w_o2 = r_v0; w_p2 = r_v2;
        case (w_in)
            3'b111: w_mode = MODE_ALL_IN;
            3'b110: begin
                w_mode = MODE_TWO_IN;
                w_q0 = r_v1; w_q1 = r_v2;
                w_o1 = r_v0; w_p1 = r_v1; w_o2 = r_v0; w_p2 = r_v2;
            end
            3'b101: begin
                w_mode = MODE_TWO_IN;
                w_q0 = r_v0; w_q1 = r_v2;
                w_o1 = r_v1; w_p1 = r_v0; w_o2 = r_v1; w_p2 = r_v2;
            end
            3'b011: begin
                w_mode = MODE_TWO_IN;
                w_q0 = r_v0; w_q1 = r_v1;
                w_o1 = r_v2; w_p1 = r_v0; w_o2 = r_v2; w_p2 = r_v1;
            end
            3'b001: begin
                w_mode = MODE_ONE_IN;
                w_q0 = r_v0;
                w_o1 = r_v1; w_p1 = r_v0; w_o2 = r_v2; w_p2 = r_v0;
            end
            3'b010: begin
                w_mode = MODE_ONE_IN;
                w_q0 = r_v1;
                w_o1 = r_v0; w_p1 = r_v1; w_o2 = r_v2; w_p2 = r_v1;
            end
            3'b100: begin
                w_mode = MODE_ONE_IN;
                w_q0 = r_v2;
                w_o1 = r_v0; w_p1 = r_v2; w_o2 = r_v1; w_p2 = r_v2;
            end
            default: w_mode = MODE_NONE;
        endcase
    end

    always_comb begin
        n_side.mode = w_mode;
        n_side.q0   = w_q0;
        n_side.q1   = w_q1;
        n_side.q2   = w_q2;
        n_side.o1   = w_o1;
        n_side.o2   = w_o2;
        n_side.d1   = delta(w_p1, w_o1);
        n_side.d2   = delta(w_p2, w_o2);
        n_c1        = div_init(w_o1, w_p1, w_near);
        n_c2        = div_init(w_o2, w_p2, w_near);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v0   <= i_v0;
            r_v1   <= i_v1;
            r_v2   <= i_v2;
            r_near <= i_near;
            r_side <= n_side;
            r_c1   <= n_c1;
            r_c2   <= n_c2;
        end
    end

    assign o_valid = r_vld2;
    assign o_side  = r_side;
    assign o_c1    = r_c1;
    assign o_c2    = r_c2;

endmodule

/* sv/ncl_div.sv */
// Pipelined restoring divider pair, two quotient bits per stage (one in the last stage).
module ncl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  ncl_pkg::t_side                i_side,
    input  ncl_pkg::t_dcr                 i_c1,
    input  ncl_pkg::t_dcr                 i_c2,
    output logic                          o_valid,
    output ncl_pkg::t_side                o_side,
    output logic [ncl_pkg::T_BITS-1:0]    o_t1,
    output logic [ncl_pkg::T_BITS-1:0]    o_t2
);
    import ncl_pkg::*;

    logic  r_vld  [DIV_STAGES];
    t_side r_side [DIV_STAGES];
    t_dcr  r_c1   [DIV_STAGES];
    t_dcr  r_c2   [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_st
        localparam int K0 = 2 * j;
        localparam int K1 = 2 * j + 1;
        logic  w_vld;
        t_side w_side;
        t_dcr  w_a1, w_a2, w_m1, w_m2, w_b1, w_b2;

        if (j == 0) begin : g_head
            assign w_vld  = i_valid;
            assign w_side = i_side;
            assign w_a1   = i_c1;
            assign w_a2   = i_c2;
        end else begin : g_body
            assign w_vld  = r_vld[j-1];
            assign w_side = r_side[j-1];
            assign w_a1   = r_c1[j-1];
            assign w_a2   = r_c2[j-1];
        end

        assign w_m1 = div_step(w_a1, K0 != 0);
        assign w_m2 = div_step(w_a2, K0 != 0);

        if (K1 < T_BITS) begin : g_two
            assign w_b1 = div_step(w_m1, 1'b1);
            assign w_b2 = div_step(w_m2, 1'b1);
        end else begin : g_one
            assign w_b1 = w_m1;
            assign w_b2 = w_m2;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j] <= w_side;
                r_c1[j]   <= w_b1;
                r_c2[j]   <= w_b2;
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];
    assign o_t1    = r_c1[DIV_STAGES-1].quo;
    assign o_t2    = r_c2[DIV_STAGES-1].quo;

endmodule

/* sv/ncl_interp.sv */
// Crossing-point interpolation: magnitude, split multiply, rounding, saturating add.
module ncl_interp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  ncl_pkg::t_side                i_side,
    input  logic [ncl_pkg::T_BITS-1:0]    i_t1,
    input  logic [ncl_pkg::T_BITS-1:0]    i_t2,
    output logic                          o_valid,
    output ncl_pkg::t_side                o_side,
    output ncl_pkg::t_vtx                 o_p1,
    output ncl_pkg::t_vtx                 o_p2
);
    import ncl_pkg::*;

    localparam int HALF = COORD_W / 2;
    localparam int PW   = HALF + T_BITS;

    // stage 0: magnitudes
    logic               r0_vld;
    t_side              r0_side;
    logic [T_BITS-1:0]  r0_t   [2];
    logic [COORD_W-1:0] r0_mag [2][3];
    logic               r0_neg [2][3];
    // stage 1: partial products
    logic               r1_vld;
    t_side              r1_side;
    logic [PW-1:0]      r1_hi  [2][3];
    logic [PW-1:0]      r1_lo  [2][3];
    logic               r1_neg [2][3];
    // stage 2: rounded offsets
    logic               r2_vld;
    t_side              r2_side;
    logic [COORD_W-1:0] r2_off [2][3];
    logic               r2_neg [2][3];
    // stage 3: crossing points
    logic               r3_vld;
    t_side              r3_side;
    t_vtx               r3_p1, r3_p2;

    logic signed [COORD_W:0]   w_d [2][3];
    logic signed [COORD_W-1:0] w_o [2][3];
    logic [COORD_W-1:0]        n_mag [2][3];
    logic [PW-1:0]             n_hi  [2][3];
    logic [PW-1:0]             n_lo  [2][3];
    logic [COORD_W-1:0]        n_off [2][3];
    logic signed [COORD_W-1:0] n_p   [2][3];

    assign w_d[0][0] = i_side.d1.x;
    assign w_d[0][1] = i_side.d1.y;
    assign w_d[0][2] = i_side.d1.z;
    assign w_d[1][0] = i_side.d2.x;
    assign w_d[1][1] = i_side.d2.y;
    assign w_d[1][2] = i_side.d2.z;
    assign w_o[0][0] = r2_side.o1.x;
    assign w_o[0][1] = r2_side.o1.y;
    assign w_o[0][2] = r2_side.o1.z;
    assign w_o[1][0] = r2_side.o2.x;
    assign w_o[1][1] = r2_side.o2.y;
    assign w_o[1][2] = r2_side.o2.z;

    always_comb begin
        logic [COORD_W:0]   neg_d;
        logic [63:0]        sum;
        logic signed [COORD_W+1:0] off;
        for (int c = 0; c < 2; c++) begin
            for (int k = 0; k < 3; k++) begin
                neg_d = -w_d[c][k];
                n_mag[c][k] = w_d[c][k][COORD_W] ? neg_d[COORD_W-1:0]
                                                 : w_d[c][k][COORD_W-1:0];
                n_hi[c][k] = PW'(r0_mag[c][k][COORD_W-1:HALF] * r0_t[c]);
                n_lo[c][k] = PW'(r0_mag[c][k][HALF-1:0] * r0_t[c]);
                sum = (64'(r1_hi[c][k]) << HALF) + 64'(r1_lo[c][k])
                    + (64'd1 << (T_FRAC - 1));
                n_off[c][k] = sum[T_FRAC+COORD_W-1:T_FRAC];
                off = r2_neg[c][k] ? -$signed({2'b00, r2_off[c][k]})
                                   : $signed({2'b00, r2_off[c][k]});
                n_p[c][k] = sat32(off + (COORD_W+2)'(w_o[c][k]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_valid;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_side <= i_side;
            r1_side <= r0_side;
            r2_side <= r1_side;
            r3_side <= r2_side;
            r0_t[0] <= i_t1;
            r0_t[1] <= i_t2;
            for (int c = 0; c < 2; c++) begin
                for (int k = 0; k < 3; k++) begin
                    r0_mag[c][k] <= n_mag[c][k];
                    r0_neg[c][k] <= w_d[c][k][COORD_W];
                    r1_hi[c][k]  <= n_hi[c][k];
                    r1_lo[c][k]  <= n_lo[c][k];
                    r1_neg[c][k] <= r0_neg[c][k];
                    r2_off[c][k] <= n_off[c][k];
                    r2_neg[c][k] <= r1_neg[c][k];
                end
            end
            r3_p1 <= '{x: n_p[0][0], y: n_p[0][1], z: n_p[0][2]};
            r3_p2 <= '{x: n_p[1][0], y: n_p[1][1], z: n_p[1][2]};
        end
    end

    assign o_valid = r3_vld;
    assign o_side  = r3_side;
    assign o_p1    = r3_p1;
    assign o_p2    = r3_p2;

endmodule

/* sv/ncl_emit.sv */
// Triangle assembly, output register and pipeline advance control.
module ncl_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ncl_pkg::t_side  i_side,
    input  ncl_pkg::t_vtx   i_p1,
    input  ncl_pkg::t_vtx   i_p2,
    input  logic            i_stall,
    output logic            o_en,
    output logic            o_valid,
    output ncl_pkg::t_tri   o_tri,
    output logic            o_last
);
    import ncl_pkg::*;

    logic r_out_valid;
    logic r_second;
    t_tri r_tri;
    logic r_last;

    logic w_free;
    logic w_consume;
    t_tri n_tri;
    logic n_last;

    assign w_free = !r_out_valid || !i_stall;

    // item leaves the last stage once its final triangle is loaded, or without waiting if it yields none
    assign w_consume = i_valid && ((i_side.mode == MODE_NONE) ||
                       (w_free && ((i_side.mode != MODE_TWO_IN) || r_second)));
    assign o_en = !i_valid || w_consume;

    always_comb begin
        n_tri  = r_tri;
        n_last = r_last;
        case (i_side.mode)
            MODE_ALL_IN: begin
                n_tri  = '{a: i_side.q0, b: i_side.q1, c: i_side.q2};
                n_last = 1'b1;
            end
            MODE_TWO_IN: begin
                if (!r_second) begin
                    n_tri  = '{a: i_p1, b: i_side.q0, c: i_side.q1};
                    n_last = 1'b0;
                end else begin
                    n_tri  = '{a: i_p1, b: i_p2, c: i_side.q1};
                    n_last = 1'b1;
                end
            end
            MODE_ONE_IN: begin
                n_tri  = '{a: i_p1, b: i_side.q0, c: i_p2};
                n_last = 1'b1;
            end
            default: begin
                n_tri  = r_tri;
                n_last = r_last;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else if (w_free) begin
            r_out_valid <= i_valid && (i_side.mode != MODE_NONE);
            if (i_valid && (i_side.mode == MODE_TWO_IN)) begin
                r_second <= !r_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_tri  <= n_tri;
            r_last <= n_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_tri   = r_tri;
    assign o_last  = r_last;

endmodule

/* sv/near_plane_triangle_clipper.sv */
// An accepted item passes through the front, divider and interpolation stages into the output register.
// Throughput: one item per cycle when it yields no triangle, or one triangle while the output register
// is free; an item that yields two triangles holds the pipeline until its second triangle is loaded.
// Front, divider and interp stages advance on one shared enable, held only while the last item waits to load.
// Reset (synchronous, active low) clears all valid bits and sets near_plane to 10.0.
module near_plane_triangle_clipper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // triangle input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [31:0]            i_v0_x,
    input  logic signed [31:0]            i_v0_y,
    input  logic signed [31:0]            i_v0_z,
    input  logic signed [31:0]            i_v1_x,
    input  logic signed [31:0]            i_v1_y,
    input  logic signed [31:0]            i_v1_z,
    input  logic signed [31:0]            i_v2_x,
    input  logic signed [31:0]            i_v2_y,
    input  logic signed [31:0]            i_v2_z,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ncl_pkg::NEAR_W-1:0]    i_cfg_near_plane,
    // triangle output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [31:0]            o_a_x,
    output logic signed [31:0]            o_a_y,
    output logic signed [31:0]            o_a_z,
    output logic signed [31:0]            o_b_x,
    output logic signed [31:0]            o_b_y,
    output logic signed [31:0]            o_b_z,
    output logic signed [31:0]            o_c_x,
    output logic signed [31:0]            o_c_y,
    output logic signed [31:0]            o_c_z,
    output logic                          o_last_tri
);
    import ncl_pkg::*;

    // Pipeline map:
    //   front  : 2 stages  - capture, classify vertices, set up num/den and deltas
    //   div    : 16 stages - two restoring steps per stage (one in the last), t = num*2^30/den for
    //                        both crossings in parallel
    //   interp : 4 stages  - |d|, split multiply, round, signed add + saturate
    //   emit   : 1 stage   - output register; two-triangle items take two slots

    logic [NEAR_W-1:0] r_near;

    logic  w_en;
    logic  f_valid, d_valid, m_valid;
    t_side f_side, d_side, m_side;
    t_dcr  f_c1, f_c2;
    logic [T_BITS-1:0] d_t1, d_t2;
    t_vtx  m_p1, m_p2;
    t_tri  w_tri;
    t_vtx  w_v0, w_v1, w_v2;

    // register is always writable; writes should happen only while idle, which the block itself does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= NEAR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_near <= i_cfg_near_plane;
        end
    end

    // input stall follows the shared pipeline enable
    assign o_stall = !w_en;

    assign w_v0 = {i_v0_x, i_v0_y, i_v0_z};
    assign w_v1 = {i_v1_x, i_v1_y, i_v1_z};
    assign w_v2 = {i_v2_x, i_v2_y, i_v2_z};

    ncl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_v0    (w_v0),
        .i_v1    (w_v1),
        .i_v2    (w_v2),
        .i_near  (r_near),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_c1    (f_c1),
        .o_c2    (f_c2)
    );

    ncl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_c1    (f_c1),
        .i_c2    (f_c2),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_t1    (d_t1),
        .o_t2    (d_t2)
    );

    ncl_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (d_valid),
        .i_side  (d_side),
        .i_t1    (d_t1),
        .i_t2    (d_t2),
        .o_valid (m_valid),
        .o_side  (m_side),
        .o_p1    (m_p1),
        .o_p2    (m_p2)
    );

    ncl_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m_valid),
        .i_side  (m_side),
        .i_p1    (m_p1),
        .i_p2    (m_p2),
        .i_stall (i_stall),
        .o_en    (w_en),
        .o_valid (o_valid),
        .o_tri   (w_tri),
        .o_last  (o_last_tri)
    );

    assign o_a_x = w_tri.a.x;
    assign o_a_y = w_tri.a.y;
    assign o_a_z = w_tri.a.z;
    assign o_b_x = w_tri.b.x;
    assign o_b_y = w_tri.b.y;
    assign o_b_z = w_tri.b.z;
    assign o_c_x = w_tri.c.x;
    assign o_c_y = w_tri.c.y;
    assign o_c_z = w_tri.c.z;

endmodule
